// ----- rtl/fresnel_pkg.sv -----
package fresnel_pkg;

    localparam int VEC_WIDTH_DEF = 16;
    localparam logic [15:0] ONE_Q12  = 16'd4096;
    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [15:0] ONE_Q15  = 16'd32768;

endpackage

// ----- rtl/fresnel_reflectance.sv -----
// throughput: one request per cycle while the output stage does not stall;
// set by the fully pipelined square root and divider stages
// a held output with tready low stalls the whole pipeline, nothing is dropped
// reset: rst_n asynchronous active low clears all valid bits; no state survives an item
module fresnel_reflectance
#(
    parameter int VEC_WIDTH = fresnel_pkg::VEC_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, refr_index
    input  logic [((6*VEC_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // reflectance
    output logic [15:0]          m_axis_tdata,
    // total_reflection, also set for a zero refractive index
    output logic                 m_axis_tuser
);

    localparam int FB = VEC_WIDTH - 2;
    localparam int PW = 2*VEC_WIDTH;

    logic en;
    logic out_valid_reg;
    logic [15:0] out_data_reg;
    logic out_user_reg;
    logic pipe_valid;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // stage 1: products
    logic signed [VEC_WIDTH-1:0] nv [3];
    logic signed [VEC_WIDTH-1:0] dv [3];
    logic signed [PW-1:0] p_reg [3];
    logic [15:0] idx1_reg;
    logic v1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = s_axis_tdata[i*VEC_WIDTH +: VEC_WIDTH];
            dv[i] = s_axis_tdata[(i+3)*VEC_WIDTH +: VEC_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= PW'(dv[i]) * PW'(nv[i]);
            end
            idx1_reg <= s_axis_tdata[6*VEC_WIDTH +: 16];
        end
    end

    // stage 2: scale to q28 and sum, clamp
    function automatic logic signed [PW+28:0] to_q28(input logic signed [PW-1:0] p);
        logic signed [PW+28:0] e;
        logic signed [PW+28:0] r;
        begin
            e = (PW+29)'(p);
            if (2*FB > 28)
            begin
                if (e < 0)
                    r = -((-e) >>> ((2*FB-28) & 63));
                else
                    r = e >>> ((2*FB-28) & 63);
            end
            else
            begin
                r = e <<< ((28-2*FB) & 63);
            end
            to_q28 = r;
        end
    endfunction

    logic signed [PW+30:0] dot_sum;
    logic signed [29:0] dot2_reg;
    logic [15:0] idx2_reg;
    logic v2_reg;

    assign dot_sum = (PW+31)'(to_q28(p_reg[0])) + (PW+31)'(to_q28(p_reg[1]))
                   + (PW+31)'(to_q28(p_reg[2]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dot_sum > (PW+31)'(signed'({1'b0, fresnel_pkg::ONE_Q28})))
                dot2_reg <= 30'sh1000_0000;
            else if (dot_sum < -(PW+31)'(signed'({1'b0, fresnel_pkg::ONE_Q28})))
                dot2_reg <= -30'sh1000_0000;
            else
                dot2_reg <= 30'(dot_sum);
            idx2_reg <= idx1_reg;
        end
    end

    // stage 3: media and cosine magnitude
    logic [28:0] cosa3_reg;
    logic [15:0] etai3_reg, etat3_reg;
    logic zero3_reg;
    logic v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosa3_reg <= dot2_reg[29] ? 29'(-dot2_reg) : dot2_reg[28:0];
            if (dot2_reg > 0)
            begin
                etai3_reg <= idx2_reg;
                etat3_reg <= fresnel_pkg::ONE_Q12;
            end
            else
            begin
                etai3_reg <= fresnel_pkg::ONE_Q12;
                etat3_reg <= idx2_reg;
            end
            zero3_reg <= (idx2_reg == 16'd0);
        end
    end

    // stage 4: square and complement
    logic [57:0] sq4_reg;
    logic [28:0] cosa4_reg;
    logic [15:0] etai4_reg, etat4_reg;
    logic zero4_reg;
    logic v4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq4_reg   <= 58'(cosa3_reg) * 58'(cosa3_reg);
            cosa4_reg <= cosa3_reg;
            etai4_reg <= etai3_reg;
            etat4_reg <= etat3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    logic [29:0] sqs4;
    logic [28:0] rem4;
    assign sqs4 = sq4_reg[57:28];
    assign rem4 = (sqs4 >= 30'(fresnel_pkg::ONE_Q28)) ? 29'd0 : 29'(30'(fresnel_pkg::ONE_Q28) - sqs4);

    // square root for sine of incidence, side data delayed alongside
    localparam int SQD = 29;
    logic [28:0] sini;
    logic v_s1;
    logic [28:0] cosa_d  [SQD];
    logic [15:0] etai_d  [SQD];
    logic [15:0] etat_d  [SQD];
    logic        zero_d  [SQD];

    fresnel_sqrt u_sqrt_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .radicand  ({1'b0, rem4, 28'd0}),
        .in_valid  (v4_reg),
        .root      (sini),
        .out_valid (v_s1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosa_d[0] <= cosa4_reg;
            etai_d[0] <= etai4_reg;
            etat_d[0] <= etat4_reg;
            zero_d[0] <= zero4_reg;
            for (int i = 1; i < SQD; i++)
            begin
                cosa_d[i] <= cosa_d[i-1];
                etai_d[i] <= etai_d[i-1];
                etat_d[i] <= etat_d[i-1];
                zero_d[i] <= zero_d[i-1];
            end
        end
    end

    // stage: sini * etai
    logic [44:0] se_reg;
    logic [15:0] etat5_reg, etai5_reg;
    logic [28:0] cosa5_reg;
    logic zero5_reg;
    logic v5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_reg    <= 45'(sini) * 45'(etai_d[SQD-1]);
            etat5_reg <= etat_d[SQD-1];
            etai5_reg <= etai_d[SQD-1];
            cosa5_reg <= cosa_d[SQD-1];
            zero5_reg <= zero_d[SQD-1] || (etat_d[SQD-1] == 16'd0);
        end
    end

    // divide for sint
    localparam int TAG1 = 1 + 16 + 16 + 29;
    logic [44:0] sint_q;
    logic [TAG1-1:0] tag1_out;
    logic v_d1;

    fresnel_div #(.NUM_W(45), .DEN_W(16), .Q_W(45), .TAG_W(TAG1)) u_div_t
    (
        .clk     (clk),
        .en      (en),
        .num     (se_reg),
        .den     (zero5_reg ? 16'd1 : etat5_reg),
        .tag_in  ({zero5_reg, etai5_reg, etat5_reg, cosa5_reg}),
        .quo     (sint_q),
        .tag_out (tag1_out)
    );

    // valid chain: sqrt has its own; here we track stages 1 to 4, stage 5 and the divider
    logic [44:0] vdiv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vdiv_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v_s1;
            vdiv_reg <= {vdiv_reg[43:0], v5_reg};
        end
    end
    assign v_d1 = vdiv_reg[44];

    // stage 6: tir decision and sint square
    logic tir6_reg, zero6_reg;
    logic [57:0] ssq6_reg;
    logic [15:0] etai6_reg, etat6_reg;
    logic [28:0] cosa6_reg;
    logic v6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tir6_reg  <= (sint_q >= 45'(fresnel_pkg::ONE_Q28));
            ssq6_reg  <= 58'(sint_q[28:0]) * 58'(sint_q[28:0]);
            zero6_reg <= tag1_out[TAG1-1];
            etai6_reg <= tag1_out[60:45];
            etat6_reg <= tag1_out[44:29];
            cosa6_reg <= tag1_out[28:0];
        end
    end

    logic [29:0] ssqs;
    logic [28:0] rem6;
    assign ssqs = ssq6_reg[57:28];
    assign rem6 = (ssqs >= 30'(fresnel_pkg::ONE_Q28)) ? 29'd0 : 29'(30'(fresnel_pkg::ONE_Q28) - ssqs);

    logic [28:0] cost;
    logic v_s2;
    logic [28:0] cosa_e [SQD];
    logic [15:0] etai_e [SQD];
    logic [15:0] etat_e [SQD];
    logic        force_e [SQD];

    fresnel_sqrt u_sqrt_t
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .radicand  ({1'b0, rem6, 28'd0}),
        .in_valid  (v6_reg),
        .root      (cost),
        .out_valid (v_s2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosa_e[0]  <= cosa6_reg;
            etai_e[0]  <= etai6_reg;
            etat_e[0]  <= etat6_reg;
            force_e[0] <= zero6_reg || tir6_reg;
            for (int i = 1; i < SQD; i++)
            begin
                cosa_e[i]  <= cosa_e[i-1];
                etai_e[i]  <= etai_e[i-1];
                etat_e[i]  <= etat_e[i-1];
                force_e[i] <= force_e[i-1];
            end
        end
    end

    // stage 7: four products
    logic [44:0] a7_reg, b7_reg, c7_reg, d7_reg;
    logic force7_reg;
    logic v7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a7_reg <= 45'(etat_e[SQD-1]) * 45'(cosa_e[SQD-1]);
            b7_reg <= 45'(etai_e[SQD-1]) * 45'(cost);
            c7_reg <= 45'(etai_e[SQD-1]) * 45'(cosa_e[SQD-1]);
            d7_reg <= 45'(etat_e[SQD-1]) * 45'(cost);
            force7_reg <= force_e[SQD-1];
        end
    end

    // stage 8: sums, differences
    logic [45:0] ds8_reg, dp8_reg, ns8_reg, np8_reg;
    logic force8_reg, bad8_reg;
    logic v8_reg;
    logic [45:0] ds_c, dp_c;

    assign ds_c = 46'(a7_reg) + 46'(b7_reg);
    assign dp_c = 46'(c7_reg) + 46'(d7_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds8_reg <= ds_c;
            dp8_reg <= dp_c;
            ns8_reg <= (a7_reg >= b7_reg) ? 46'(a7_reg - b7_reg) : 46'(b7_reg - a7_reg);
            np8_reg <= (c7_reg >= d7_reg) ? 46'(c7_reg - d7_reg) : 46'(d7_reg - c7_reg);
            force8_reg <= force7_reg;
            bad8_reg <= (ds_c == 46'd0) || (dp_c == 46'd0);
        end
    end

    // stage 9: normalize below 2^32, clamp numerators to denominators
    function automatic logic [5:0] norm_sh(input logic [45:0] d);
        logic [5:0] s;
        begin
            s = 6'd0;
            for (int i = 32; i < 46; i++)
            begin
                if (d[i])
                    s = 6'(i - 31);
            end
            norm_sh = s;
        end
    endfunction

    logic [32:0] ds9_reg, dp9_reg, ns9_reg, np9_reg;
    logic force9_reg, bad9_reg;
    logic v9_reg;
    logic [45:0] nsn, npn, dsn, dpn;

    assign dsn = ds8_reg >> norm_sh(ds8_reg);
    assign dpn = dp8_reg >> norm_sh(dp8_reg);
    assign nsn = ns8_reg >> norm_sh(ds8_reg);
    assign npn = np8_reg >> norm_sh(dp8_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds9_reg <= dsn[32:0];
            dp9_reg <= dpn[32:0];
            ns9_reg <= (nsn > dsn) ? dsn[32:0] : nsn[32:0];
            np9_reg <= (npn > dpn) ? dpn[32:0] : npn[32:0];
            force9_reg <= force8_reg;
            bad9_reg <= bad8_reg;
        end
    end

    // ratio dividers, force flag rides with the s divider and bad flag with the p divider
    logic [30:0] rs_q, rp_q;
    logic force_q, bad_q;

    fresnel_div #(.NUM_W(63), .DEN_W(33), .Q_W(31), .TAG_W(1)) u_div_s
    (
        .clk     (clk),
        .en      (en),
        .num     ({ns9_reg, 30'd0}),
        .den     (bad9_reg ? 33'd1 : ds9_reg),
        .tag_in  (force9_reg),
        .quo     (rs_q),
        .tag_out (force_q)
    );

    fresnel_div #(.NUM_W(63), .DEN_W(33), .Q_W(31), .TAG_W(1)) u_div_p
    (
        .clk     (clk),
        .en      (en),
        .num     ({np9_reg, 30'd0}),
        .den     (bad9_reg ? 33'd1 : dp9_reg),
        .tag_in  (bad9_reg),
        .quo     (rp_q),
        .tag_out (bad_q)
    );

    // stage 10: squares
    logic [61:0] rs2_reg, rp2_reg;
    logic force10_reg, bad10_reg;
    logic v10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs2_reg <= 62'(rs_q) * 62'(rs_q);
            rp2_reg <= 62'(rp_q) * 62'(rp_q);
            force10_reg <= force_q;
            bad10_reg <= bad_q;
        end
    end

    logic [62:0] rsum;
    logic [16:0] rval;
    assign rsum = 63'(rs2_reg) + 63'(rp2_reg) + (63'd1 << 45);
    assign rval = rsum[62:46];

    // valid chain from stage 6 on
    logic [30:0] vr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            vr_reg <= '0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v_d1;
            v7_reg <= v_s2;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            vr_reg <= {vr_reg[29:0], v9_reg};
            v10_reg <= vr_reg[30];
        end
    end

    assign pipe_valid = v10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_user_reg <= force10_reg;
            if (force10_reg || bad10_reg || rval > 17'(fresnel_pkg::ONE_Q15))
                out_data_reg <= fresnel_pkg::ONE_Q15;
            else
                out_data_reg <= rval[15:0];
        end
    end

endmodule

// ----- rtl/fresnel_sqrt.sv -----
module fresnel_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [57:0] radicand,
    input  logic        in_valid,
    output logic [28:0] root,
    output logic        out_valid
);

    localparam int STEPS = 29;

    logic [57:0] x_reg  [STEPS+1];
    logic [28:0] r_reg  [STEPS+1];
    logic [STEPS:0] v_reg;

    assign x_reg[0] = radicand;
    assign r_reg[0] = '0;
    assign v_reg[0] = in_valid;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_step
            localparam int B = STEPS - 1 - g;
            logic [59:0] trial;
            logic [57:0] x_next;
            logic [28:0] r_next;
            // (2*r + 2^b) * 2^b with r holding the root bits above b
            assign trial = ({31'd0, r_reg[g]} << (B + 1)) + (60'd1 << (2*B));
            always_comb
            begin
                x_next = x_reg[g];
                r_next = r_reg[g];
                if ({2'b00, x_reg[g]} >= trial)
                begin
                    x_next = x_reg[g] - trial[57:0];
                    r_next = r_reg[g] | (29'd1 << B);
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[g+1] <= v_reg[g];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g+1] <= x_next;
                    r_reg[g+1] <= r_next;
                end
            end
        end
    endgenerate

    assign root      = r_reg[STEPS];
    assign out_valid = v_reg[STEPS];

endmodule

// ----- rtl/fresnel_div.sv -----
module fresnel_div
#(
    parameter int NUM_W = 45,
    parameter int DEN_W = 33,
    parameter int Q_W   = 31,
    parameter int TAG_W = 8
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [Q_W-1:0]   quo,
    output logic [TAG_W-1:0] tag_out
);

    logic [NUM_W-1:0] n_reg [Q_W+1];
    logic [DEN_W-1:0] d_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg [Q_W+1];
    logic [TAG_W-1:0] t_reg [Q_W+1];

    assign n_reg[0] = num;
    assign d_reg[0] = den;
    assign q_reg[0] = '0;
    assign t_reg[0] = tag_in;

    genvar g;
    generate
        for (g = 0; g < Q_W; g++)
        begin : g_step
            localparam int SH = Q_W - 1 - g;
            logic [NUM_W+Q_W-1:0] dsh;
            logic [NUM_W-1:0]     n_next;
            logic [Q_W-1:0]       q_next;
            assign dsh = {{(NUM_W+Q_W-DEN_W){1'b0}}, d_reg[g]} << SH;
            always_comb
            begin
                n_next = n_reg[g];
                q_next = q_reg[g];
                if ({{Q_W{1'b0}}, n_reg[g]} >= dsh)
                begin
                    n_next = n_reg[g] - dsh[NUM_W-1:0];
                    q_next[SH] = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[g+1] <= n_next;
                    d_reg[g+1] <= d_reg[g];
                    q_reg[g+1] <= q_next;
                    t_reg[g+1] <= t_reg[g];
                end
            end
        end
    endgenerate

    assign quo     = q_reg[Q_W];
    assign tag_out = t_reg[Q_W];

endmodule

// ----- verif/tb_fresnel_reflectance.sv -----
module tb_fresnel_reflectance;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 16;
    localparam int IN_W = ((6*VW+16+7)/8)*8;
    localparam int LATENCY = 144;
    localparam longint ONE28 = 64'd1 << 28;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] refl;
        logic        tir;
    } refl_t;

    typedef struct {
        logic [15:0] nx, ny, nz, dx, dy, dz, idx;
        logic        known;
        logic [15:0] refl;
        logic        tir;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic m_axis_tuser;

    refl_t pending_q[$];
    int errors = 0;
    int cycles = 0;
    int stall_cnt;
    bit recv_rand = 1'b0;

    fresnel_reflectance uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned complement_q28(longint unsigned c);
        longint unsigned sq;
        longint unsigned rem;
        sq = (c * c) >> 28;
        rem = (sq >= ONE28) ? 0 : ONE28 - sq;
        return root_floor(rem << 28);
    endfunction

    function automatic longint unsigned amp_ratio(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        n = (num < 0) ? -num : num;
        d = den;
        while (d >= (64'd1 << 32))
        begin
            d >>= 1;
            n >>= 1;
        end
        if (n > d)
            n = d;
        return (n << 30) / d;
    endfunction

    // Q2.14 products are already Q28
    function automatic refl_t fresnel_predict(logic [15:0] nx, logic [15:0] ny,
            logic [15:0] nz, logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
            logic [15:0] idx);
        refl_t r;
        longint dot;
        longint unsigned etai, etat, cosa, sini, sint, cost, rs, rp, acc;
        longint ds, dp;
        dot = longint'($signed(dx)) * longint'($signed(nx))
            + longint'($signed(dy)) * longint'($signed(ny))
            + longint'($signed(dz)) * longint'($signed(nz));
        if (dot > ONE28) dot = ONE28;
        if (dot < -ONE28) dot = -ONE28;
        r.refl = 16'd32768;
        r.tir = 1'b1;
        if (idx == 0)
            return r;
        etai = 4096;
        etat = idx;
        if (dot > 0)
        begin
            etai = idx;
            etat = 4096;
        end
        cosa = (dot < 0) ? -dot : dot;
        sini = complement_q28(cosa);
        sint = (sini * etai) / etat;
        if (sint >= ONE28)
            return r;
        cost = complement_q28(sint);
        r.tir = 1'b0;
        ds = longint'(etat * cosa + etai * cost);
        dp = longint'(etai * cosa + etat * cost);
        if (ds <= 0 || dp <= 0)
            return r;
        rs = amp_ratio(longint'(etat * cosa) - longint'(etai * cost), ds);
        rp = amp_ratio(longint'(etai * cosa) - longint'(etat * cost), dp);
        acc = (rs * rs + rp * rp + (64'd1 << 45)) >> 46;
        if (acc > 32768)
            acc = 32768;
        r.refl = acc[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: always ready until recv_rand is set, then stalls of random length, mostly short and a few long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (!recv_rand)
            m_axis_tready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= int'($urandom_range(10, 60));
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) < 75);
    end

    always @(posedge clk)
    begin
        refl_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected request", m_axis_tdata, 0);
            else
            begin
                e = pending_q.pop_front();
                if (m_axis_tdata !== e.refl)
                    report_mismatch("reflectance", m_axis_tdata, e.refl);
                if (m_axis_tuser !== e.tir)
                    report_mismatch("total_reflection", m_axis_tuser, e.tir);
            end
        end
    end

    task automatic send_request(row_t rw);
        refl_t e;
        s_axis_tdata <= {rw.idx, rw.dz, rw.dy, rw.dx, rw.nz, rw.ny, rw.nx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        e = fresnel_predict(rw.nx, rw.ny, rw.nz, rw.dx, rw.dy, rw.dz, rw.idx);
        if (rw.known)
        begin
            e.refl = rw.refl;
            e.tir = rw.tir;
        end
        pending_q.push_back(e);
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 99) < 60)
            return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [15:0] unit_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return 16'h4000;
        if (k == 2)
            return 16'hC000;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    row_t dir_rows[$];

    initial
    begin
        row_t rw;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nx ny nz dx dy dz idx known refl tir
        dir_rows = '{
            '{16'h4000, 0, 0, 16'hC000, 0, 0, 16'd0, 1, 16'd32768, 1},
            '{16'h4000, 0, 0, 16'hC000, 0, 0, 16'd6144, 0, 0, 0},
            '{16'h4000, 0, 0, 16'h4000, 0, 0, 16'd6144, 0, 0, 0},
            '{16'h4000, 0, 0, 0, 16'h4000, 0, 16'd6144, 0, 0, 0},
            '{16'h4000, 0, 0, 16'h1000, 16'h3000, 0, 16'd6144, 1, 16'd32768, 1},
            '{16'h4000, 0, 0, 16'hC000, 0, 0, 16'd4096, 1, 16'd0, 0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'hFFFF, 0, 0, 0},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'hFFFF, 0, 0, 0},
            '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'd1, 0, 0, 0},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001,
              16'd1, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 16'd8192, 0, 0, 0},
            '{16'h2D41, 16'h2D41, 0, 16'hE000, 16'hD000, 16'h1000, 16'd5461, 0, 0, 0},
            '{16'h2D41, 16'h2D41, 0, 16'h2000, 16'h3000, 16'h1000, 16'd5461, 0, 0, 0},
            '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
              16'h5555, 0, 0, 0},
            '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
              16'hAAAA, 0, 0, 0}
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        recv_rand = 1'b1;

        for (int i = 0; i < 1500; i++)
        begin
            if (i == 700)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            rw.known = 1'b0;
            rw.refl = 0;
            rw.tir = 0;
            rw.nx = unit_comp();
            rw.ny = unit_comp();
            rw.nz = unit_comp();
            rw.dx = unit_comp();
            rw.dy = unit_comp();
            rw.dz = unit_comp();
            case ($urandom_range(0, 9))
                0: rw.idx = 16'($urandom);
                1: rw.idx = 16'd0;
                default: rw.idx = 16'($urandom_range(4096, 12288));
            endcase
            send_request(rw);
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 30) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/fresnel_pkg.sv
rtl/fresnel_sqrt.sv
rtl/fresnel_div.sv
rtl/fresnel_reflectance.sv
verif/tb_fresnel_reflectance.sv
